// File: rtl/alc_pkg.sv
`default_nettype none

package alc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned CapacityDef  = 128;
  localparam int unsigned ValueBitsDef = 32;

  // Fixed field widths on the stream ports
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_FIRST  = 2'd1,
    OP_NEXT   = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_END      = 2'd2,
    ST_NOCURSOR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_READ  = 2'd1,
    S_SHIFT = 2'd2
  } state_e;

endpackage

`default_nettype wire

// File: rtl/array_list_with_cursor.sv
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid_i/tready_o       tuser: op, tdata: item_value
// m_axis    out  m_axis_tvalid_o/tready_i       tuser: status, tdata: out_value, stored_count
//
// Insert completes in the cycle it is accepted; first and next do one
// registered store read, or end at once with a status. Remove reads the entry
// at the cursor, then moves the count - cursor - 1 entries after it down, one
// store move per cycle through the single read/write port pair. Reset clears
// count, cursor and the output valid flag, not the entry store. Input is taken
// only in the idle state and only when the output register is empty or being
// emptied, so a stall on the result side holds off the next item.
module array_list_with_cursor
  import alc_pkg::*;
#(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,   // [31:0] item_value
  input  wire logic [OpW-1:0]      s_axis_tuser_i,   // [1:0] op
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic      [OutDataW-1:0] m_axis_tdata_o,   // [31:0] out_value, [39:32] stored_count
  output logic      [StatusW-1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned CntXW = CntW + 1;

  // Sequencer state
  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                cur_valid_q, cur_valid_d;
  logic [AddrW-1:0]    cur_q, cur_d;
  logic [AddrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [ValueW-1:0]   removed_q, removed_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [ValueW-1:0]   out_value_q;
  logic [CountW-1:0]   out_count_q;

  logic                load_out;
  status_e             ld_status;
  logic [ValueW-1:0]   ld_value;
  logic [CountW-1:0]   ld_count;
  logic [15:0]         count_ext;

  // Store port controls
  logic                  mem_wr_en;
  logic [AddrW-1:0]      mem_wr_addr;
  logic [VALUE_BITS-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [AddrW-1:0]      mem_rd_addr;
  logic [VALUE_BITS-1:0] mem_rd_data;

  // Value width conversion: keep low VALUE_BITS bits, read back zero-extended
  logic [63:0]           in_wide;
  logic [63:0]           rd_wide;
  logic [VALUE_BITS-1:0] in_val;
  logic [ValueW-1:0]     rd_val;

  // Shared conditions
  op_e                 op_in;
  logic                in_acc;
  logic                list_full;
  logic                list_empty;
  logic [CntW-1:0]     next_idx;
  logic                next_end;
  logic                no_cursor;
  logic                more_after_read;
  logic                more_after_move;

  assign op_in   = op_e'(s_axis_tuser_i);
  assign in_wide = 64'(s_axis_tdata_i);
  assign in_val  = in_wide[VALUE_BITS-1:0];
  assign rd_wide = 64'(mem_rd_data);
  assign rd_val  = rd_wide[ValueW-1:0];

  // Accept only when idle and the result slot will be free at this edge
  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign list_full  = (count_q == CntW'(CAPACITY));
  assign list_empty = (count_q == '0);
  // Next from no position starts at entry 0
  assign next_idx   = cur_valid_q ? (CntW'(cur_q) + CntW'(1)) : '0;
  assign next_end   = (next_idx >= count_q);
  assign no_cursor  = !cur_valid_q || (CntW'(cur_q) >= count_q);
  // Entries still to move down after the current write pointer
  assign more_after_read = (CntXW'(wr_ptr_q) + CntXW'(1)) < CntXW'(count_q);
  assign more_after_move = (CntXW'(wr_ptr_q) + CntXW'(2)) < CntXW'(count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op_in)
            OP_FIRST:  if (!list_empty) state_d = S_READ;
            OP_NEXT:   if (!next_end)   state_d = S_READ;
            OP_REMOVE: if (!no_cursor)  state_d = S_READ;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        if ((op_q == OP_REMOVE) && more_after_read) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        state_d = more_after_move ? S_SHIFT : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates
  always_comb begin
    op_d        = op_q;
    count_d     = count_q;
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    wr_ptr_d    = wr_ptr_q;
    removed_d   = removed_q;
    load_out    = 1'b0;
    ld_status   = ST_OK;
    ld_value    = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = wr_ptr_q;
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d = op_in;
          case (op_in)
            OP_INSERT: begin
              load_out = 1'b1;
              if (list_full) begin
                ld_status = ST_FULL;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = count_q[AddrW-1:0];
                mem_wr_data = in_val;
                count_d     = count_q + CntW'(1);
              end
            end
            OP_FIRST: begin
              if (list_empty) begin
                load_out  = 1'b1;
                ld_status = ST_END;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                cur_valid_d = 1'b1;
                cur_d       = '0;
              end
            end
            OP_NEXT: begin
              if (next_end) begin
                load_out  = 1'b1;
                ld_status = ST_END;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = next_idx[AddrW-1:0];
                cur_valid_d = 1'b1;
                cur_d       = next_idx[AddrW-1:0];
              end
            end
            OP_REMOVE: begin
              if (no_cursor) begin
                load_out  = 1'b1;
                ld_status = ST_NOCURSOR;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = cur_q;
                wr_ptr_d    = cur_q;
              end
            end
            default: begin
              load_out = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        if (op_q == OP_REMOVE) begin
          removed_d = rd_val;
          if (more_after_read) begin
            // Fetch the entry that moves into the vacated slot
            mem_rd_en   = 1'b1;
            mem_rd_addr = wr_ptr_q + AddrW'(1);
          end else begin
            load_out    = 1'b1;
            ld_value    = rd_val;
            count_d     = count_q - CntW'(1);
            cur_valid_d = (cur_q != '0);
            cur_d       = cur_q - AddrW'(1);
          end
        end else begin
          load_out = 1'b1;
          ld_value = rd_val;
        end
      end
      S_SHIFT: begin
        // Write the fetched entry one place down; fetch the one after it while entries remain
        mem_wr_en   = 1'b1;
        mem_wr_addr = wr_ptr_q;
        mem_wr_data = mem_rd_data;
        wr_ptr_d    = wr_ptr_q + AddrW'(1);
        if (more_after_move) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = wr_ptr_q + AddrW'(2);
        end else begin
          load_out    = 1'b1;
          ld_value    = removed_q;
          count_d     = count_q - CntW'(1);
          cur_valid_d = (cur_q != '0);
          cur_d       = cur_q - AddrW'(1);
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  assign count_ext = 16'(count_d);
  assign ld_count  = count_ext[CountW-1:0];

  // Hold a result until taken; a new one only lands in an empty or draining slot
  assign out_valid_d = load_out || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_INSERT;
      count_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_q       <= '0;
      wr_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      count_q     <= count_d;
      cur_valid_q <= cur_valid_d;
      cur_q       <= cur_d;
      wr_ptr_q    <= wr_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
    if (load_out) begin
      out_status_q <= ld_status;
      out_value_q  <= ld_value;
      out_count_q  <= ld_count;
    end
  end

  alc_ram #(
    .Depth (CAPACITY),
    .Width (VALUE_BITS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_count_q, out_value_q};
  assign m_axis_tuser_o  = out_status_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (CntW'(cur_q) < count_q))
    else $error("cursor points past the held entries");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_valid_q)
    else $error("result slot occupied while an item is in progress");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == $past(count_q) + CntW'(1)) || (count_q == $past(count_q) - CntW'(1))))
    else $error("entry count moved by more than one");

  a_shift_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SHIFT) && !more_after_move) |=> (state_q == S_IDLE) && out_valid_q)
    else $error("remove finished without delivering a result");
`endif

endmodule

`default_nettype wire

// File: rtl/alc_ram.sv
`default_nettype none

// Simple dual-port storage: one write and one registered read per cycle.
module alc_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire
